// File: hdl/bsd_pkg.sv
package bsd_pkg;

  // Datapath sizing
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;

  localparam int SMP_W = SAMPLE_WIDTH;
  localparam int LVL_W = SAMPLE_WIDTH - 1;
  localparam int POW_W = 2 * SAMPLE_WIDTH - 1;
  localparam int CNT_W = COUNT_WIDTH;
  localparam int ACC_W = COUNT_WIDTH + 1;

  // Stream word sizes
  localparam int IN_FIELDS_W  = SMP_W + 2 * POW_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POW_W;

  localparam logic [CFG_IDX_W-1:0] REG_POWER_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_NEEDED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd6;

  // Detector modes
  localparam logic [1:0] MODE_WAIT  = 2'd0;
  localparam logic [1:0] MODE_EVAL  = 2'd1;
  localparam logic [1:0] MODE_TRACK = 2'd2;

  typedef struct packed {
    logic [POW_W-1:0] power_high;
    logic [POW_W-1:0] power_low;
    logic [LVL_W-1:0] sat_level;
    logic [CNT_W-1:0] sat_needed;
    logic [CNT_W-1:0] attack_needed;
    logic [CNT_W-1:0] release_limit;
    logic [CNT_W-1:0] window_len;
  } bsd_cfg_t;

  typedef struct packed {
    logic [SMP_W-1:0] audio_sample;  // two's complement
    logic [POW_W-1:0] fast_power;
    logic [POW_W-1:0] slow_power;
  } bsd_item_t;

  typedef struct packed {
    logic [1:0] detector_mode;
    logic       blow_detected;
  } bsd_result_t;

endpackage

// File: hdl/bsd_cfg_regs.sv
module bsd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bsd_pkg::bsd_cfg_t              cfg_o
);

  bsd_pkg::bsd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bsd_pkg::REG_POWER_HIGH: cfg_d.power_high    = cfg_data_i[bsd_pkg::POW_W-1:0];
        bsd_pkg::REG_POWER_LOW:  cfg_d.power_low     = cfg_data_i[bsd_pkg::POW_W-1:0];
        bsd_pkg::REG_SAT_LEVEL:  cfg_d.sat_level     = cfg_data_i[bsd_pkg::LVL_W-1:0];
        bsd_pkg::REG_SAT_NEEDED: cfg_d.sat_needed    = cfg_data_i[bsd_pkg::CNT_W-1:0];
        bsd_pkg::REG_ATTACK:     cfg_d.attack_needed = cfg_data_i[bsd_pkg::CNT_W-1:0];
        bsd_pkg::REG_RELEASE:    cfg_d.release_limit = cfg_data_i[bsd_pkg::CNT_W-1:0];
        bsd_pkg::REG_WINDOW_LEN: cfg_d.window_len    = cfg_data_i[bsd_pkg::CNT_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_high    <= '0;
      cfg_q.power_low     <= '0;
      cfg_q.sat_level     <= '1;
      cfg_q.sat_needed    <= bsd_pkg::CNT_W'(20);
      cfg_q.attack_needed <= bsd_pkg::CNT_W'(1);
      cfg_q.release_limit <= bsd_pkg::CNT_W'(1);
      cfg_q.window_len    <= bsd_pkg::CNT_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/bsd_fsm.sv
module bsd_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bsd_pkg::bsd_cfg_t    cfg_i,
  input  logic                 step_en_i,
  input  bsd_pkg::bsd_item_t   item_i,
  output bsd_pkg::bsd_result_t result_o
);

  localparam logic [bsd_pkg::ACC_W-1:0] ACC_MAX = '1;

  logic [1:0]                mode_q, mode_d;
  logic [bsd_pkg::CNT_W-1:0] timer_q, timer_d;
  logic [bsd_pkg::ACC_W-1:0] sat_cnt_q, sat_cnt_d;
  logic [bsd_pkg::ACC_W-1:0] pow_cnt_q, pow_cnt_d;

  logic [bsd_pkg::SMP_W-1:0] mag;
  logic                      saturated;
  logic [bsd_pkg::CNT_W-1:0] timer_dec;
  logic [bsd_pkg::ACC_W-1:0] sat_cnt_inc, pow_cnt_inc, pow_cnt_trk, sat_cnt_ev, pow_cnt_ev;

  // |x|; the most negative code maps to 2^(w-1) and is always saturated
  assign mag = item_i.audio_sample[bsd_pkg::SMP_W-1] ? (~item_i.audio_sample + 1'b1)
                                                      : item_i.audio_sample;
  assign saturated = mag > {1'b0, cfg_i.sat_level};

  assign sat_cnt_inc = (sat_cnt_q == ACC_MAX) ? sat_cnt_q : sat_cnt_q + 1'b1;
  assign pow_cnt_inc = (pow_cnt_q == ACC_MAX) ? pow_cnt_q : pow_cnt_q + 1'b1;
  assign timer_dec   = (timer_q != '0) ? timer_q - 1'b1 : timer_q;

  assign pow_cnt_trk = (item_i.slow_power <= cfg_i.power_low) ? pow_cnt_inc : pow_cnt_q;
  assign sat_cnt_ev  = saturated ? sat_cnt_inc : sat_cnt_q;
  assign pow_cnt_ev  = (item_i.fast_power >= cfg_i.power_high) ? pow_cnt_inc : pow_cnt_q;

  always_comb begin
    mode_d    = mode_q;
    timer_d   = timer_q;
    sat_cnt_d = sat_cnt_q;
    pow_cnt_d = pow_cnt_q;
    unique case (mode_q)
      bsd_pkg::MODE_TRACK: begin
        pow_cnt_d = pow_cnt_trk;
        sat_cnt_d = '0;
        timer_d   = '0;
        if (pow_cnt_trk > {1'b0, cfg_i.release_limit}) begin
          mode_d = bsd_pkg::MODE_WAIT;
        end
      end
      bsd_pkg::MODE_EVAL: begin
        timer_d   = timer_dec;
        sat_cnt_d = sat_cnt_ev;
        pow_cnt_d = pow_cnt_ev;
        if (sat_cnt_ev > {1'b0, cfg_i.sat_needed} &&
            pow_cnt_ev >= {1'b0, cfg_i.attack_needed}) begin
          mode_d    = bsd_pkg::MODE_TRACK;
          pow_cnt_d = '0;
        end else if (timer_dec == '0) begin
          mode_d = bsd_pkg::MODE_WAIT;
        end
      end
      default: begin  // waiting, and the unused code
        mode_d    = bsd_pkg::MODE_WAIT;
        pow_cnt_d = '0;
        if (saturated) begin
          mode_d    = bsd_pkg::MODE_EVAL;
          timer_d   = cfg_i.window_len;
          sat_cnt_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= bsd_pkg::MODE_WAIT;
      timer_q   <= '0;
      sat_cnt_q <= '0;
      pow_cnt_q <= '0;
    end else if (step_en_i) begin
      mode_q    <= mode_d;
      timer_q   <= timer_d;
      sat_cnt_q <= sat_cnt_d;
      pow_cnt_q <= pow_cnt_d;
    end
  end

  assign result_o.detector_mode = mode_d;
  assign result_o.blow_detected = (mode_d == bsd_pkg::MODE_TRACK);

  a_track_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && mode_q == bsd_pkg::MODE_TRACK) |=> (timer_q == '0 && sat_cnt_q == '0))
    else $error("tracking step left timer or saturated count nonzero");

  a_wait_exits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && mode_q != bsd_pkg::MODE_TRACK && mode_q != bsd_pkg::MODE_EVAL)
      |=> (mode_q == bsd_pkg::MODE_WAIT || mode_q == bsd_pkg::MODE_EVAL))
    else $error("waiting step jumped straight to tracking");

  a_enter_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mode_q == bsd_pkg::MODE_TRACK) |-> (pow_cnt_q == '0))
    else $error("power count not cleared on entry to tracking");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(mode_q) && $stable(pow_cnt_q))
    else $error("state moved without a step");

endmodule

// File: hdl/blow_saturation_detector.sv
// Blow saturation detector: waiting / evaluating / tracking on saturation and power.
// Result path: the input register takes the accepted word, then the result register
// takes its mode/flag word and drives m_axis_tvalid_o; the state update is one
// compare/increment pass. Throughput: one word per cycle while the result side is ready.
// Backpressure on the result side stalls the input register, then s_axis_tready_o.
// Reset (rst_ni, async, low): mode waiting, counters and timer zero, registers at defaults,
// both pipeline registers empty.
module blow_saturation_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [15:0] audio_sample, [46:16] fast_power, [77:47] slow_power, [79:78] zero
  input  logic [bsd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] detector_mode, [2] blow_detected, [7:3] zero
  output logic [bsd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int FastLo = bsd_pkg::SMP_W;
  localparam int SlowLo = bsd_pkg::SMP_W + bsd_pkg::POW_W;

  bsd_pkg::bsd_cfg_t    cfg;
  bsd_pkg::bsd_item_t   in_word_q;
  bsd_pkg::bsd_result_t result, out_word_q;

  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic s_accept, advance;

  bsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input word moves into the result register when that register is free or drains.
  // The detector state advances exactly on that move, so words are processed in order.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_word_q.audio_sample <= s_axis_tdata_i[bsd_pkg::SMP_W-1:0];
      in_word_q.fast_power   <= s_axis_tdata_i[FastLo +: bsd_pkg::POW_W];
      in_word_q.slow_power   <= s_axis_tdata_i[SlowLo +: bsd_pkg::POW_W];
    end
    if (advance) begin
      out_word_q <= result;
    end
  end

  bsd_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_en_i (advance),
    .item_i    (in_word_q),
    .result_o  (result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{bsd_pkg::OUT_PAD_W{1'b0}}, out_word_q.blow_detected,
                            out_word_q.detector_mode};

endmodule

// File: tb/sv/blow_saturation_detector_tb.sv
module blow_saturation_detector_tb;

  localparam logic [bsd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register here
  localparam logic [bsd_pkg::POW_W-1:0]     POW_MAX    = {bsd_pkg::POW_W{1'b1}};
  localparam logic [bsd_pkg::ACC_W-1:0]     ACC_MAX    = {bsd_pkg::ACC_W{1'b1}};
  localparam int MAG_W          = bsd_pkg::SMP_W + 1;
  localparam int RX_HOLD_CYCLES = 300;     // long receiver hold-off, fills the pipe
  localparam int CYCLE_LIMIT    = 400000;  // worst case is far below this
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_WORDS    = 90;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  // [15:0] audio_sample, [46:16] fast_power, [77:47] slow_power, [79:78] zero
  logic [bsd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  // [1:0] detector_mode, [2] blow_detected, [7:3] zero
  logic [bsd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  blow_saturation_detector u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Detector copy kept by the bench: registers plus the four state items.
  bsd_pkg::bsd_cfg_t         det_cfg;
  logic [1:0]                det_mode;
  logic [bsd_pkg::CNT_W-1:0] det_timer;
  logic [bsd_pkg::ACC_W-1:0] det_sat_cnt;
  logic [bsd_pkg::ACC_W-1:0] det_pow_cnt;

  bsd_pkg::bsd_result_t expected_modes[$];  // mode/flag words still owed by the DUT

  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned track_entries;
  int unsigned settings_used;
  int unsigned cycle_count;

  // Idle control shared with the receiver process.
  logic        tx_steady;  // sender: no gaps while set
  logic        rx_steady;  // receiver: no new random stalls while set
  int unsigned hold_req;   // bump to ask for one long receiver hold-off
  int unsigned hold_seen;
  int unsigned rx_stall;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [bsd_pkg::ACC_W-1:0] bump_count(logic [bsd_pkg::ACC_W-1:0] c);
    return (c == ACC_MAX) ? c : c + 1'b1;
  endfunction

  function automatic void reset_detector();
    det_cfg.power_high    = '0;
    det_cfg.power_low     = '0;
    det_cfg.sat_level     = {bsd_pkg::LVL_W{1'b1}};
    det_cfg.sat_needed    = 16'd20;
    det_cfg.attack_needed = 16'd1;
    det_cfg.release_limit = 16'd1;
    det_cfg.window_len    = 16'd1;
    det_mode    = bsd_pkg::MODE_WAIT;
    det_timer   = '0;
    det_sat_cnt = '0;
    det_pow_cnt = '0;
  endfunction

  // Advances the detector copy by one sample and returns the word it owes.
  function automatic bsd_pkg::bsd_result_t step_detector(bsd_pkg::bsd_item_t it);
    logic [MAG_W-1:0]     mag;
    logic                 saturated;
    bsd_pkg::bsd_result_t res;
    // most negative sample has magnitude 32768, always above any level
    mag = it.audio_sample[bsd_pkg::SMP_W-1] ? (17'h10000 - {1'b0, it.audio_sample})
                                            : {1'b0, it.audio_sample};
    saturated = mag > {2'b00, det_cfg.sat_level};
    if (det_mode == bsd_pkg::MODE_TRACK) begin
      if (it.slow_power <= det_cfg.power_low) det_pow_cnt = bump_count(det_pow_cnt);
      // count survives into waiting, the next waiting step clears it
      if (det_pow_cnt > {1'b0, det_cfg.release_limit}) det_mode = bsd_pkg::MODE_WAIT;
      det_sat_cnt = '0;
      det_timer   = '0;
    end else if (det_mode == bsd_pkg::MODE_EVAL) begin
      if (det_timer != 0) det_timer = det_timer - 1'b1;  // sticks at zero
      if (saturated) det_sat_cnt = bump_count(det_sat_cnt);
      if (it.fast_power >= det_cfg.power_high) det_pow_cnt = bump_count(det_pow_cnt);
      if (det_sat_cnt > {1'b0, det_cfg.sat_needed} &&
          det_pow_cnt >= {1'b0, det_cfg.attack_needed}) begin
        det_mode    = bsd_pkg::MODE_TRACK;
        det_pow_cnt = '0;
        track_entries++;
      end else if (det_timer == 0) begin
        det_mode = bsd_pkg::MODE_WAIT;
      end
    end else begin
      // waiting, and the unused code behaves the same
      det_mode    = bsd_pkg::MODE_WAIT;
      det_pow_cnt = '0;
      if (saturated) begin
        det_timer   = det_cfg.window_len;
        det_sat_cnt = '0;
        det_mode    = bsd_pkg::MODE_EVAL;
      end
    end
    res.detector_mode = det_mode;
    res.blow_detected = (det_mode == bsd_pkg::MODE_TRACK);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, one long hold-off on request, compare in order
  // ---------------------------------------------------------------------------
  function automatic void check_word(logic [bsd_pkg::OUT_DATA_W-1:0] data);
    bsd_pkg::bsd_result_t want;
    bsd_pkg::bsd_result_t got;
    got.detector_mode = data[1:0];
    got.blow_detected = data[2];
    if (expected_modes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: mode %0d blow %0d",
                 got.detector_mode, got.blow_detected);
      return;
    end
    want = expected_modes.pop_front();
    words_checked++;
    if (got.detector_mode !== want.detector_mode ||
        got.blow_detected !== want.blow_detected) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: mode exp %0d got %0d, blow exp %0d got %0d",
                 words_checked, want.detector_mode, got.detector_mode,
                 want.blow_detected, got.blow_detected);
    end
  endfunction

  always @(posedge clk_i) begin : rx_side
    int r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_word(m_axis_tdata_o);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rx_stall  = RX_HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_steady) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 70) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          // mostly short stalls, now and then a long one
          m_axis_tready_i <= 1'b0;
          rx_stall = (r < 95) ? $urandom_range(2, 0) : $urandom_range(40, 8);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_modes.size());
      $display("blow_saturation_detector_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // valid is only lowered for a gap or a drain, so back-to-back words keep it high
  task automatic send_word(bsd_pkg::bsd_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(bsd_pkg::IN_DATA_W - bsd_pkg::IN_FIELDS_W){1'b0}},
                        it.slow_power, it.fast_power, it.audio_sample};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_modes.push_back(step_detector(it));
    words_sent++;
  endtask

  // Stop offering and wait until the DUT has handed back everything it owes.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_modes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);  // two-stage pipe, a little margin
  endtask

  task automatic write_reg(logic [bsd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bsd_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      bsd_pkg::REG_POWER_HIGH: det_cfg.power_high    = val;
      bsd_pkg::REG_POWER_LOW:  det_cfg.power_low     = val;
      bsd_pkg::REG_SAT_LEVEL:  det_cfg.sat_level     = val[bsd_pkg::LVL_W-1:0];
      bsd_pkg::REG_SAT_NEEDED: det_cfg.sat_needed    = val[bsd_pkg::CNT_W-1:0];
      bsd_pkg::REG_ATTACK:     det_cfg.attack_needed = val[bsd_pkg::CNT_W-1:0];
      bsd_pkg::REG_RELEASE:    det_cfg.release_limit = val[bsd_pkg::CNT_W-1:0];
      bsd_pkg::REG_WINDOW_LEN: det_cfg.window_len    = val[bsd_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(bsd_pkg::bsd_cfg_t c);
    write_reg(bsd_pkg::REG_POWER_HIGH, c.power_high);
    write_reg(bsd_pkg::REG_POWER_LOW, c.power_low);
    write_reg(bsd_pkg::REG_SAT_LEVEL, bsd_pkg::CFG_DATA_W'(c.sat_level));
    write_reg(bsd_pkg::REG_SAT_NEEDED, bsd_pkg::CFG_DATA_W'(c.sat_needed));
    write_reg(bsd_pkg::REG_ATTACK, bsd_pkg::CFG_DATA_W'(c.attack_needed));
    write_reg(bsd_pkg::REG_RELEASE, bsd_pkg::CFG_DATA_W'(c.release_limit));
    write_reg(bsd_pkg::REG_WINDOW_LEN, bsd_pkg::CFG_DATA_W'(c.window_len));
    settings_used++;
  endtask

  function automatic bsd_pkg::bsd_item_t make_item(logic [bsd_pkg::SMP_W-1:0] smp,
                                                   logic [bsd_pkg::POW_W-1:0] fast,
                                                   logic [bsd_pkg::POW_W-1:0] slow);
    bsd_pkg::bsd_item_t it;
    it.audio_sample = smp;
    it.fast_power   = fast;
    it.slow_power   = slow;
    return it;
  endfunction

  function automatic logic [bsd_pkg::SMP_W-1:0] signed_sample(logic [MAG_W-1:0] mag);
    logic [bsd_pkg::SMP_W-1:0] s;
    if (mag[bsd_pkg::SMP_W]) return 16'h8000;
    s = mag[bsd_pkg::SMP_W-1:0];
    return $urandom_range(1) ? -s : s;
  endfunction

  // Saturated sample with fast power meeting the attack threshold.
  function automatic bsd_pkg::bsd_item_t loud_item();
    logic [MAG_W-1:0] mag;
    mag = MAG_W'($urandom_range(32768, int'(det_cfg.sat_level) + 1));
    return make_item(signed_sample(mag),
                     bsd_pkg::POW_W'($urandom_range(POW_MAX, det_cfg.power_high)),
                     bsd_pkg::POW_W'($urandom));
  endfunction

  // Unsaturated sample with slow power at or below the release threshold.
  function automatic bsd_pkg::bsd_item_t quiet_item();
    logic [MAG_W-1:0] mag;
    mag = MAG_W'($urandom_range(int'(det_cfg.sat_level), 0));
    return make_item(signed_sample(mag), bsd_pkg::POW_W'($urandom),
                     bsd_pkg::POW_W'($urandom_range(det_cfg.power_low, 0)));
  endfunction

  function automatic bsd_pkg::bsd_item_t noise_item();
    return make_item(bsd_pkg::SMP_W'($urandom), bsd_pkg::POW_W'($urandom),
                     bsd_pkg::POW_W'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: only the most negative sample counts as saturated.
  task automatic test_defaults();
    send_word(make_item(16'h0000, '0, '0));
    send_word(make_item(16'h7fff, POW_MAX, POW_MAX));
    send_word(make_item(16'h8001, POW_MAX, '0));
    send_word(make_item(16'h8000, POW_MAX, POW_MAX));  // starts a one-sample window
    send_word(make_item(16'h8000, '0, '0));
    send_word(make_item(16'h0001, '0, POW_MAX));
    drain_results();
  endtask

  // Full waiting -> evaluating -> tracking -> waiting pass, then a window with no attack power.
  task automatic test_attack_release();
    bsd_pkg::bsd_cfg_t c;
    c.power_high    = 31'd5000;
    c.power_low     = 31'd300;
    c.sat_level     = 15'd1000;
    c.sat_needed    = 16'd1;
    c.attack_needed = 16'd2;
    c.release_limit = 16'd1;
    c.window_len    = 16'd4;
    write_all(c);
    write_reg(REG_UNUSED, bsd_pkg::CFG_DATA_W'($urandom));  // must not disturb anything
    send_word(make_item(16'd2000, 31'd6000, 31'd9000));
    send_word(make_item(-16'sd2000, 31'd5000, 31'd9000));
    send_word(make_item(16'd1001, 31'd7000, 31'd9000));
    send_word(make_item(16'd10, 31'd0, 31'd300));  // low slow power while tracking
    send_word(make_item(16'd10, 31'd0, 31'd301));
    send_word(make_item(16'd10, 31'd0, 31'd0));    // passes release count
    send_word(make_item(16'd1001, 31'd0, 31'd0));  // window with no attack power
    send_word(make_item(16'd5, 31'd0, 31'd0));
    send_word(make_item(16'd5, 31'd0, 31'd0));
    send_word(make_item(16'd5, 31'd0, 31'd0));
    drain_results();
  endtask

  // Zero window length behaves as a one-sample window; level zero and wide thresholds.
  task automatic test_window_and_extremes();
    write_reg(bsd_pkg::REG_WINDOW_LEN, '0);
    write_reg(bsd_pkg::REG_SAT_LEVEL, '0);
    write_reg(bsd_pkg::REG_POWER_HIGH, POW_MAX);
    write_reg(bsd_pkg::REG_POWER_LOW, '0);
    send_word(make_item(16'hffff, POW_MAX - 1'b1, POW_MAX));
    send_word(make_item(16'h0000, POW_MAX, '0));
    send_word(make_item(16'h0001, POW_MAX, '0));
    send_word(make_item(16'h8000, POW_MAX, '0));
    drain_results();
  endtask

  // Receiver holds off for a long stretch while words keep coming, then the
  // sender pauses until every owed result is back.
  task automatic test_backpressure();
    bsd_pkg::bsd_cfg_t c;
    c.power_high    = 31'd1 << 20;
    c.power_low     = 31'd1 << 18;
    c.sat_level     = 15'd8000;
    c.sat_needed    = 16'd2;
    c.attack_needed = 16'd2;
    c.release_limit = 16'd3;
    c.window_len    = 16'd6;
    write_all(c);
    tx_steady <= 1'b1;
    hold_req  <= hold_req + 1;
    repeat (40) begin
      if ($urandom_range(3) != 0) send_word(loud_item());
      else send_word(quiet_item());
    end
    drain_results();
    tx_steady <= 1'b0;
  endtask

  function automatic bsd_pkg::bsd_cfg_t pick_settings(int phase);
    bsd_pkg::bsd_cfg_t c;
    c.power_high    = bsd_pkg::POW_W'($urandom);
    c.power_low     = bsd_pkg::POW_W'($urandom);
    c.sat_level     = bsd_pkg::LVL_W'($urandom_range(32766, 0));
    c.sat_needed    = bsd_pkg::CNT_W'($urandom_range(6, 0));
    c.attack_needed = bsd_pkg::CNT_W'($urandom_range(6, 0));
    c.release_limit = bsd_pkg::CNT_W'($urandom_range(8, 0));
    c.window_len    = bsd_pkg::CNT_W'(($urandom_range(4) == 0) ? $urandom_range(3, 0)
                      : int'(c.sat_needed) + int'(c.attack_needed) + 2
                        + int'($urandom_range(4, 0)));
    if (phase == 0) begin
      // minimum of every register
      c = '0;
    end else if (phase == 1) begin
      // maximum of every register: only full-scale negative saturates, no tracking
      c.power_high    = POW_MAX;
      c.power_low     = POW_MAX;
      c.sat_level     = {bsd_pkg::LVL_W{1'b1}};
      c.sat_needed    = 16'hffff;
      c.attack_needed = 16'hffff;
      c.release_limit = 16'hffff;
      c.window_len    = 16'hffff;
    end else if (phase == 2) begin
      // long window and release limit, reachable attack
      c.window_len    = 16'hffff;
      c.release_limit = 16'd20;
    end
    return c;
  endfunction

  // Mostly well-formed attack/release sequences with random content, plus
  // broken bursts and plain noise.
  task automatic test_random_phases();
    int                n;
    int                r;
    int                len;
    int unsigned       base;
    bsd_pkg::bsd_cfg_t c;
    for (int p = 0; p < RAND_PHASES; p++) begin
      c = pick_settings(p);
      write_all(c);
      tx_steady <= (p == 4);
      rx_steady <= (p == 4) || (p == 7);
      base = words_sent;
      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 65) begin
          len = int'(det_cfg.sat_needed) + 1 + int'($urandom_range(2, 0));
          if (len > 24) len = 24;
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0) send_word(noise_item());
            else send_word(loud_item());
          end
          len = int'(det_cfg.release_limit) + 1 + int'($urandom_range(3, 0));
          if (len > 24) len = 24;
          for (int i = 0; i < len; i++) send_word(quiet_item());
        end else if (r < 80) begin
          len = $urandom_range(3, 1);
          for (int i = 0; i < len; i++) send_word(loud_item());
          send_word(noise_item());
        end else begin
          len = $urandom_range(8, 1);
          for (int i = 0; i < len; i++) send_word(noise_item());
        end
        n = int'(words_sent - base);
      end
      drain_results();
    end
    tx_steady <= 1'b0;
    rx_steady <= 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;
    tx_steady       <= 1'b0;
    rx_steady       <= 1'b0;
    hold_req        <= 0;
    hold_seen        = 0;
    rx_stall         = 0;
    words_sent       = 0;
    words_checked    = 0;
    mismatches       = 0;
    track_entries    = 0;
    settings_used    = 0;
    cycle_count      = 0;
    reset_detector();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_attack_release();
    test_window_and_extremes();
    test_backpressure();
    test_random_phases();

    drain_results();
    if (expected_modes.size() != 0) mismatches += expected_modes.size();
    $display("sent %0d words over %0d register settings, checked %0d results",
             words_sent, settings_used, words_checked);
    $display("tracking entered %0d times, %0d mismatches", track_entries, mismatches);
    if (mismatches == 0) begin
      $display("blow_saturation_detector_tb: clean");
    end else begin
      $display("blow_saturation_detector_tb: errors");
    end
    $finish;
  end

endmodule
